// ===== design/wsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CHUNK_W = 64;
  localparam int unsigned CHUNKS  = 4;
  localparam int unsigned PAT_W   = CHUNK_W * CHUNKS;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_CHUNK_0        = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHUNK_1        = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHUNK_2        = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHUNK_3        = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic advance;
    logic blank;
  } stage_ctrl_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

// ===== design/wsd_text_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wsd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       start_of_text;

  modport source (output valid, output text_byte, output start_of_text, input ready);
  modport sink (input valid, input text_byte, input start_of_text, output ready);
endinterface

`default_nettype wire

// ===== design/wsd_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wsd_result_if;
  logic valid;
  logic ready;
  logic match_now;
  logic found;

  modport source (output valid, output match_now, output found, input ready);
  modport sink (input valid, input match_now, input found, output ready);
endinterface

`default_nettype wire

// ===== design/word_substring_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Word substring detector.
// Text words arrive on the text channel (valid/ready), one byte per word,
// with start_of_text marking the first byte of a new text. Each accepted
// byte produces exactly one result word on the result channel: match_now
// is high when the configured pattern ends at that byte inside the current
// whitespace-delimited word, found is the sticky flag since start of text.
// The result is registered and valid in the cycle after acceptance; one
// byte per cycle is taken unless the receiver stalls, set by the row of
// prefix stages, all updating on acceptance, one stage per pattern byte.
// The pattern is loaded over the APB port (length at 0x00, pattern bytes
// in four 64-bit chunks at 0x08..0x20) while no text is in flight.
// Reset clears the prefix bits, the found flag, the result register and
// all configuration registers.
// The result register holds its word while the receiver stalls; text ready
// drops in the same cycle, so no byte is lost or repeated.

module word_substring_detector #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wsd_pkg::DATA_W-1:0]  pwdata,
  output logic      [wsd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  wsd_text_if.sink                         text,
  wsd_result_if.source                     result
);

  localparam int unsigned SEL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [wsd_pkg::LEN_W-1:0] MAX_LEN = wsd_pkg::LEN_W'(MAX_PATTERN);

  logic [wsd_pkg::LEN_W-1:0] pattern_length;
  logic [wsd_pkg::PAT_W-1:0] pattern;
  logic [wsd_pkg::LEN_W-1:0] len_sat;
  logic [wsd_pkg::LEN_W-1:0] len_dec;
  logic [SEL_W-1:0]          last_sel;
  logic [MAX_PATTERN-1:0]    hit;
  logic [MAX_PATTERN-1:0]    hit_next;
  logic [MAX_PATTERN-1:0]    link;
  logic [MAX_PATTERN-1:0]    enable;
  wsd_pkg::stage_ctrl_t      ctrl;
  logic                      accept;
  logic                      blank;
  logic                      match;
  logic                      found_flag;
  logic                      found_next;
  logic                      out_valid;
  logic                      match_q;

  wsd_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pattern_length (pattern_length),
    .pattern        (pattern)
  );

  assign text.ready = !out_valid || result.ready;
  assign accept     = text.valid && text.ready;
  assign blank      = wsd_pkg::is_space(text.text_byte);
  assign ctrl.advance = accept;
  assign ctrl.blank   = blank;

  assign len_sat  = (pattern_length > MAX_LEN) ? MAX_LEN : pattern_length;
  assign len_dec  = len_sat - wsd_pkg::LEN_W'(1);
  assign last_sel = len_dec[SEL_W-1:0];

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_row
      if (k == 0) begin : g_head
        assign link[k] = 1'b1;
      end else begin : g_tail
        // drop the carried prefix when a new text starts
        assign link[k] = hit[k-1] && !text.start_of_text;
      end
      assign enable[k] = (wsd_pkg::LEN_W'(k) < len_sat);

      wsd_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .text_byte (text.text_byte),
        .pat_byte  (pattern[8*k +: 8]),
        .enable    (enable[k]),
        .link      (link[k]),
        .hit       (hit[k]),
        .hit_next  (hit_next[k])
      );
    end
  endgenerate

  // empty pattern matches any byte inside a word
  assign match      = (len_sat == '0) ? !blank : hit_next[last_sel];
  assign found_next = (found_flag && !text.start_of_text) || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      found_flag <= 1'b0;
    end else begin
      if (accept) begin
        out_valid  <= 1'b1;
        found_flag <= found_next;
      end else if (result.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (accept) begin
      match_q <= match;
    end
  end

  assign result.valid     = out_valid;
  assign result.match_now = match_q;
  assign result.found     = found_flag;

  a_match_sets_found: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.match_now |-> result.found)
    else $error("match reported without found flag");

  a_space_no_match: assert property (@(posedge clk) disable iff (rst)
    accept && wsd_pkg::is_space(text.text_byte) |=> result.valid && !result.match_now)
    else $error("whitespace byte reported a match");

  a_space_clears_row: assert property (@(posedge clk) disable iff (rst)
    accept && wsd_pkg::is_space(text.text_byte) |=> (hit == '0))
    else $error("prefix bits survive a whitespace byte");

  a_start_resets_found: assert property (@(posedge clk) disable iff (rst)
    accept && text.start_of_text |=> (result.found == result.match_now))
    else $error("found flag carried across start of text");

endmodule

`default_nettype wire

// ===== design/wsd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wsd_pkg::DATA_W-1:0]  pwdata,
  output logic      [wsd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [wsd_pkg::LEN_W-1:0]   pattern_length,
  output logic      [wsd_pkg::PAT_W-1:0]   pattern
);

  logic [wsd_pkg::CHUNK_W-1:0] chunk0;
  logic [wsd_pkg::CHUNK_W-1:0] chunk1;
  logic [wsd_pkg::CHUNK_W-1:0] chunk2;
  logic [wsd_pkg::CHUNK_W-1:0] chunk3;
  logic [wsd_pkg::IDX_W-1:0]   index;
  logic                        wr;

  assign pready = 1'b1;
  assign index  = paddr[wsd_pkg::ADDR_W-1:wsd_pkg::ADDR_W-wsd_pkg::IDX_W];
  assign wr     = psel && penable && pwrite;
  assign pattern = {chunk3, chunk2, chunk1, chunk0};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      chunk0         <= '0;
      chunk1         <= '0;
      chunk2         <= '0;
      chunk3         <= '0;
    end else if (wr) begin
      unique case (index)
        wsd_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[wsd_pkg::LEN_W-1:0];
        wsd_pkg::REG_CHUNK_0:        chunk0 <= pwdata;
        wsd_pkg::REG_CHUNK_1:        chunk1 <= pwdata;
        wsd_pkg::REG_CHUNK_2:        chunk2 <= pwdata;
        wsd_pkg::REG_CHUNK_3:        chunk3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      wsd_pkg::REG_PATTERN_LENGTH:
        prdata = {{(wsd_pkg::DATA_W-wsd_pkg::LEN_W){1'b0}}, pattern_length};
      wsd_pkg::REG_CHUNK_0: prdata = chunk0;
      wsd_pkg::REG_CHUNK_1: prdata = chunk1;
      wsd_pkg::REG_CHUNK_2: prdata = chunk2;
      wsd_pkg::REG_CHUNK_3: prdata = chunk3;
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/wsd_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsd_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wsd_pkg::stage_ctrl_t ctrl,
  input  wire logic [7:0]           text_byte,
  input  wire logic [7:0]           pat_byte,
  input  wire logic                 enable,
  input  wire logic                 link,
  output logic                      hit,
  output logic                      hit_next
);

  // extend the prefix from the neighbor when this byte agrees
  assign hit_next = !ctrl.blank && enable && link && (text_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.advance) begin
      hit <= hit_next;
    end
  end

endmodule

`default_nettype wire
